[sv/visual_servo_velocity_controller_assert.svh]
// Assertion macros shared by the controller modules.
`ifndef VISUAL_SERVO_VELOCITY_CONTROLLER_ASSERT_SVH
`define VISUAL_SERVO_VELOCITY_CONTROLLER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define VSVC_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("vsvc assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define VSVC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("vsvc assertion failed");

`endif

[sv/vsvc_pkg.sv]
package vsvc_pkg;

   // Item kinds on the request channel.
   localparam logic OP_TARGET = 1'b0;
   localparam logic OP_TICK   = 1'b1;

   // Configuration register indexes.
   typedef enum logic [2:0] {
      CSR_FRAME_WIDTH   = 3'd0,
      CSR_FRAME_HEIGHT  = 3'd1,
      CSR_GAIN_X        = 3'd2,
      CSR_GAIN_Y        = 3'd3,
      CSR_DEPTH_GAIN    = 3'd4,
      CSR_DEFAULT_DEPTH = 3'd5,
      CSR_DESIRED_DEPTH = 3'd6,
      CSR_TIMEOUT_TICKS = 3'd7
   } csr_index_type;

   // Reset values of the configuration registers.
   localparam logic [12:0] RST_FRAME_WIDTH   = 13'd640;
   localparam logic [12:0] RST_FRAME_HEIGHT  = 13'd480;
   localparam logic [23:0] RST_GAIN_X        = 24'd16777;
   localparam logic [23:0] RST_GAIN_Y        = 24'd16777;
   localparam logic [15:0] RST_DEPTH_GAIN    = 16'd32768;
   localparam logic [15:0] RST_DEFAULT_DEPTH = 16'd3277;
   localparam logic [15:0] RST_DESIRED_DEPTH = 16'd3277;
   localparam logic [7:0]  RST_TIMEOUT_TICKS = 8'd5;

   // Fixed behavior constants.
   localparam logic [15:0] PHASE_STEP    = 16'd417;
   localparam logic [15:0] SEARCH_RADIUS = 16'd3277;
   localparam logic [15:0] DEPTH_MIN     = 16'd204;
   localparam logic [15:0] QUARTER_TURN  = 16'd16384;
   localparam logic [63:0] HALF_PI_Q30   = 64'd1686629713;

   // Quarter-wave sine table.
   localparam int SINE_ENTRIES = 256;
   localparam int SINE_BITS    = $clog2(SINE_ENTRIES);

   // Job queue between the front and back end.
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

   // Back-end multiply schedule.
   typedef logic [2:0] step_type;
   localparam step_type STEP_EU  = 3'd0;
   localparam step_type STEP_GX  = 3'd1;
   localparam step_type STEP_EV  = 3'd2;
   localparam step_type STEP_GY  = 3'd3;
   localparam step_type STEP_DZ  = 3'd4;
   localparam step_type STEP_OUT = 3'd5;

   // Rounding shift selection.
   typedef enum logic [1:0] {
      SHIFT_12 = 2'd0,
      SHIFT_16 = 2'd1,
      SHIFT_21 = 2'd2
   } shift_type;

   typedef struct packed {
      logic [12:0] frame_width;
      logic [12:0] frame_height;
      logic [23:0] gain_x;
      logic [23:0] gain_y;
      logic [15:0] depth_gain;
      logic [15:0] default_depth;
      logic [15:0] desired_depth;
      logic [7:0]  timeout_ticks;
   } cfg_type;

   // One control tick, classified and prepared by the front end.
   typedef struct packed {
      logic        tracking;
      logic        eu_neg;
      logic [12:0] eu_mag;
      logic        ev_neg;
      logic [12:0] ev_mag;
      logic [15:0] z;
      logic        dz_neg;
      logic [15:0] dz_mag;
      logic        s_neg;
      logic [16:0] s_mag;
      logic        c_neg;
      logic [16:0] c_mag;
   } job_type;

   typedef struct packed {
      logic    valid;
      job_type job;
   } push_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   typedef struct packed {
      logic        neg;
      logic [16:0] mag;
   } sine_type;

   typedef logic [15:0] sine_table_type [SINE_ENTRIES];

   // Fixed-point Taylor series of sin(a), a in Q30 radians, result Q0.16.
   function automatic logic [15:0] sine_q16(logic [63:0] a);
      logic [63:0]        x2;
      logic [63:0]        term;
      logic [63:0]        v;
      logic signed [63:0] sum;
      x2   = (a * a) >> 30;
      term = a;
      sum  = $signed(a);
      term = ((term * x2) >> 30) / 64'd6;
      sum  = sum - $signed(term);
      term = ((term * x2) >> 30) / 64'd20;
      sum  = sum + $signed(term);
      term = ((term * x2) >> 30) / 64'd42;
      sum  = sum - $signed(term);
      term = ((term * x2) >> 30) / 64'd72;
      sum  = sum + $signed(term);
      term = ((term * x2) >> 30) / 64'd110;
      sum  = sum - $signed(term);
      if (sum < 0) begin
         sum = '0;
      end
      v = ($unsigned(sum) + 64'd8192) >> 14;
      if (v > 64'd65535) begin
         v = 64'd65535;
      end
      return v[15:0];
   endfunction

   function automatic sine_table_type build_sine_table();
      sine_table_type t;
      for (int i = 0; i < SINE_ENTRIES; i++) begin
         t[i] = sine_q16((64'(i) * HALF_PI_Q30) / SINE_ENTRIES);
      end
      return t;
   endfunction

   localparam sine_table_type SINE_TABLE = build_sine_table();

   // Signed sine of a 16-bit phase; magnitude runs up to exactly 1.0.
   function automatic sine_type phase_sine(logic [15:0] phase);
      sine_type                res;
      logic [SINE_BITS-1:0]    idx;
      logic [SINE_BITS:0]      mirror;
      idx    = phase[13 -: SINE_BITS];
      mirror = (SINE_BITS + 1)'(SINE_ENTRIES) - {1'b0, idx};
      if (phase[14]) begin
         if (idx == '0) begin
            res.mag = 17'h10000;
         end else begin
            res.mag = {1'b0, SINE_TABLE[mirror[SINE_BITS-1:0]]};
         end
      end else begin
         res.mag = {1'b0, SINE_TABLE[idx]};
      end
      res.neg = phase[15];
      return res;
   endfunction

   // Round a magnitude to nearest (ties away from zero), apply the sign
   // and saturate to 24-bit signed.
   function automatic logic [23:0] round_sat(logic [52:0] mag, logic neg, shift_type sh);
      logic [53:0] r;
      case (sh)
         SHIFT_12: r = ({1'b0, mag} + 54'd2048) >> 12;
         SHIFT_16: r = ({1'b0, mag} + 54'd32768) >> 16;
         SHIFT_21: r = ({1'b0, mag} + 54'd1048576) >> 21;
         default:  r = '0;
      endcase
      if (neg) begin
         if (r > 54'd8388608) begin
            return 24'h800000;
         end
         return 24'd0 - r[23:0];
      end
      if (r > 54'd8388607) begin
         return 24'h7FFFFF;
      end
      return r[23:0];
   endfunction

endpackage

[sv/vsvc_front.sv]
module vsvc_front (
   input  logic                clock,
   input  logic                reset,
   input  vsvc_pkg::cfg_type   cfg,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic                req_operation,
   input  logic [11:0]         req_pixel_u,
   input  logic [11:0]         req_pixel_v,
   input  logic [15:0]         req_depth,
   input  vsvc_pkg::queue_status_type status,
   output vsvc_pkg::push_type  push
);

   logic        target_valid_ff, target_valid_in;
   logic [11:0] held_u_ff, held_u_in;
   logic [11:0] held_v_ff, held_v_in;
   logic [15:0] held_depth_ff, held_depth_in;
   logic [7:0]  target_age_ff, target_age_in;
   logic [15:0] phase_ff, phase_in;

   logic               accept;
   logic signed [14:0] eu2;
   logic signed [14:0] ev2;
   logic [14:0]        eu_abs;
   logic [14:0]        ev_abs;
   logic [15:0]        z;
   logic [16:0]        dz;
   logic [16:0]        dz_abs;
   vsvc_pkg::sine_type sin_val;
   vsvc_pkg::sine_type cos_val;
   vsvc_pkg::job_type  job;

   // Items are held off only while the job queue has no room.
   assign req_stall = status.full;
   assign accept    = req_valid && !req_stall;

   // Pixel errors in half pixels, effective depth, depth error and search sine and cosine.
   always_comb begin
      eu2     = $signed({2'b00, held_u_ff, 1'b0}) - $signed({2'b00, cfg.frame_width});
      ev2     = $signed({2'b00, held_v_ff, 1'b0}) - $signed({2'b00, cfg.frame_height});
      eu_abs  = eu2[14] ? (15'd0 - eu2) : eu2;
      ev_abs  = ev2[14] ? (15'd0 - ev2) : ev2;
      z       = (held_depth_ff > vsvc_pkg::DEPTH_MIN) ? held_depth_ff : cfg.default_depth;
      dz      = {1'b0, z} - {1'b0, cfg.desired_depth};
      dz_abs  = dz[16] ? (17'd0 - dz) : dz;
      sin_val = vsvc_pkg::phase_sine(phase_ff);
      cos_val = vsvc_pkg::phase_sine(phase_ff + vsvc_pkg::QUARTER_TURN);
   end

   // Classify the tick and pack everything the back end needs.
   always_comb begin
      job.tracking = target_valid_ff && (target_age_ff <= cfg.timeout_ticks);
      job.eu_neg   = eu2[14];
      job.eu_mag   = eu_abs[12:0];
      job.ev_neg   = ev2[14];
      job.ev_mag   = ev_abs[12:0];
      job.z        = z;
      job.dz_neg   = dz[16];
      job.dz_mag   = dz_abs[15:0];
      job.s_neg    = sin_val.neg;
      job.s_mag    = sin_val.mag;
      job.c_neg    = cos_val.neg;
      job.c_mag    = cos_val.mag;
   end

   assign push.valid = accept && (req_operation == vsvc_pkg::OP_TICK);
   assign push.job   = job;

   // Target state, age and search phase update on each transfer.
   always_comb begin
      target_valid_in = target_valid_ff;
      held_u_in       = held_u_ff;
      held_v_in       = held_v_ff;
      held_depth_in   = held_depth_ff;
      target_age_in   = target_age_ff;
      phase_in        = phase_ff;
      if (accept) begin
         if (req_operation == vsvc_pkg::OP_TARGET) begin
            target_valid_in = 1'b1;
            held_u_in       = req_pixel_u;
            held_v_in       = req_pixel_v;
            held_depth_in   = req_depth;
            target_age_in   = '0;
         end else begin
            phase_in = phase_ff + vsvc_pkg::PHASE_STEP;
            if (target_age_ff != 8'hFF) begin
               target_age_in = target_age_ff + 8'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         target_valid_ff <= 1'b0;
         held_u_ff       <= '0;
         held_v_ff       <= '0;
         held_depth_ff   <= '0;
         target_age_ff   <= '0;
         phase_ff        <= '0;
      end else begin
         target_valid_ff <= target_valid_in;
         held_u_ff       <= held_u_in;
         held_v_ff       <= held_v_in;
         held_depth_ff   <= held_depth_in;
         target_age_ff   <= target_age_in;
         phase_ff        <= phase_in;
      end
   end

endmodule

[sv/vsvc_queue.sv]
`include "visual_servo_velocity_controller_assert.svh"

module vsvc_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  vsvc_pkg::push_type         push,
   input  logic                       pop,
   output vsvc_pkg::job_type          head,
   output vsvc_pkg::queue_status_type status
);

   vsvc_pkg::job_type              entry_ff [vsvc_pkg::QUEUE_DEPTH];
   logic [vsvc_pkg::QUEUE_AW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [vsvc_pkg::QUEUE_AW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [vsvc_pkg::QUEUE_CW-1:0]  count_ff, count_in;

   localparam logic [vsvc_pkg::QUEUE_AW-1:0] LAST_PTR =
      vsvc_pkg::QUEUE_AW'(vsvc_pkg::QUEUE_DEPTH - 1);
   localparam logic [vsvc_pkg::QUEUE_CW-1:0] FULL_COUNT =
      vsvc_pkg::QUEUE_CW'(vsvc_pkg::QUEUE_DEPTH);

   assign status.full  = (count_ff == FULL_COUNT);
   assign status.empty = (count_ff == '0);
   assign head         = entry_ff[rd_ptr_ff];

   // Pointer and occupancy bookkeeping.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push.valid) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push.valid && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push.valid) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Job storage needs no reset.
   always_ff @(posedge clock) begin
      if (push.valid) begin
         entry_ff[wr_ptr_ff] <= push.job;
      end
   end

   `VSVC_ASSERT_NOW(a_no_overflow, clock, reset, push.valid, !status.full)
   `VSVC_ASSERT_NOW(a_no_underflow, clock, reset, pop, !status.empty)
   `VSVC_ASSERT_NOW(a_count_in_range, clock, reset, 1'b1, count_ff <= FULL_COUNT)

endmodule

[sv/vsvc_back.sv]
`include "visual_servo_velocity_controller_assert.svh"

module vsvc_back (
   input  logic                       clock,
   input  logic                       reset,
   input  vsvc_pkg::cfg_type          cfg,
   input  vsvc_pkg::job_type          head,
   input  vsvc_pkg::queue_status_type status,
   output logic                       pop,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic signed [23:0]         rsp_vel_x,
   output logic signed [23:0]         rsp_vel_y,
   output logic signed [23:0]         rsp_vel_z,
   output logic                       rsp_tracking
);

   typedef enum logic [1:0] {
      BK_IDLE = 2'b01,
      BK_RUN  = 2'b10
   } back_state_type;

   back_state_type      state_ff, state_in;
   vsvc_pkg::step_type  step_ff, step_in;
   vsvc_pkg::job_type   job_ff, job_in;
   logic [52:0]         mul_ff, mul_in;
   logic [23:0]         vx_ff, vx_in;
   logic [23:0]         vy_ff, vy_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [23:0]         rsp_vel_x_ff, rsp_vel_x_in;
   logic [23:0]         rsp_vel_y_ff, rsp_vel_y_in;
   logic [23:0]         rsp_vel_z_ff, rsp_vel_z_in;
   logic                rsp_tracking_ff, rsp_tracking_in;

   logic                 out_free;
   logic [28:0]          mul_a;
   logic [23:0]          mul_b;
   logic [52:0]          product;
   logic                 vx_neg;
   logic                 vy_neg;
   vsvc_pkg::shift_type  xy_shift;
   logic                 stepping;
   logic                 loading;
   logic                 search_out;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign pop      = (state_ff == BK_IDLE) && !status.empty;

   // Operand selection for the shared multiplier, one step per cycle.
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (step_ff)
         vsvc_pkg::STEP_EU: begin
            if (job_ff.tracking) begin
               mul_a = {16'd0, job_ff.eu_mag};
               mul_b = {8'd0, job_ff.z};
            end
         end
         vsvc_pkg::STEP_GX: begin
            if (job_ff.tracking) begin
               mul_a = mul_ff[28:0];
               mul_b = cfg.gain_x;
            end else begin
               mul_a = {12'd0, job_ff.s_mag};
               mul_b = {8'd0, vsvc_pkg::SEARCH_RADIUS};
            end
         end
         vsvc_pkg::STEP_EV: begin
            if (job_ff.tracking) begin
               mul_a = {16'd0, job_ff.ev_mag};
               mul_b = {8'd0, job_ff.z};
            end
         end
         vsvc_pkg::STEP_GY: begin
            if (job_ff.tracking) begin
               mul_a = mul_ff[28:0];
               mul_b = cfg.gain_y;
            end else begin
               mul_a = {12'd0, job_ff.c_mag};
               mul_b = {8'd0, vsvc_pkg::SEARCH_RADIUS};
            end
         end
         vsvc_pkg::STEP_DZ: begin
            if (job_ff.tracking) begin
               mul_a = {13'd0, job_ff.dz_mag};
               mul_b = {8'd0, cfg.depth_gain};
            end
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign product = 53'(mul_a) * 53'(mul_b);

   // Velocity points away from the error in x and y; search traces a circle.
   assign vx_neg   = job_ff.tracking ? !job_ff.eu_neg : !job_ff.s_neg;
   assign vy_neg   = job_ff.tracking ? !job_ff.ev_neg : job_ff.c_neg;
   assign xy_shift = job_ff.tracking ? vsvc_pkg::SHIFT_21 : vsvc_pkg::SHIFT_16;

   // Sequencer: pick up a job, run the multiply steps, load the output.
   always_comb begin
      state_in        = state_ff;
      step_in         = step_ff;
      job_in          = job_ff;
      mul_in          = mul_ff;
      vx_in           = vx_ff;
      vy_in           = vy_ff;
      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      rsp_vel_x_in    = rsp_vel_x_ff;
      rsp_vel_y_in    = rsp_vel_y_ff;
      rsp_vel_z_in    = rsp_vel_z_ff;
      rsp_tracking_in = rsp_tracking_ff;
      case (state_ff)
         BK_IDLE: begin
            if (!status.empty) begin
               job_in   = head;
               step_in  = vsvc_pkg::STEP_EU;
               state_in = BK_RUN;
            end
         end
         BK_RUN: begin
            if (step_ff != vsvc_pkg::STEP_OUT) begin
               mul_in  = product;
               step_in = step_ff + 3'd1;
               if (step_ff == vsvc_pkg::STEP_EV) begin
                  vx_in = vsvc_pkg::round_sat(mul_ff, vx_neg, xy_shift);
               end
               if (step_ff == vsvc_pkg::STEP_DZ) begin
                  vy_in = vsvc_pkg::round_sat(mul_ff, vy_neg, xy_shift);
               end
            end else if (out_free) begin
               rsp_valid_in    = 1'b1;
               rsp_vel_x_in    = vx_ff;
               rsp_vel_y_in    = vy_ff;
               rsp_vel_z_in    = vsvc_pkg::round_sat(mul_ff, job_ff.dz_neg,
                                                     vsvc_pkg::SHIFT_12);
               rsp_tracking_in = job_ff.tracking;
               state_in        = BK_IDLE;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         step_ff      <= vsvc_pkg::STEP_EU;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath and result payload carry no reset.
   always_ff @(posedge clock) begin
      job_ff          <= job_in;
      mul_ff          <= mul_in;
      vx_ff           <= vx_in;
      vy_ff           <= vy_in;
      rsp_vel_x_ff    <= rsp_vel_x_in;
      rsp_vel_y_ff    <= rsp_vel_y_in;
      rsp_vel_z_ff    <= rsp_vel_z_in;
      rsp_tracking_ff <= rsp_tracking_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_vel_x    = rsp_vel_x_ff;
   assign rsp_vel_y    = rsp_vel_y_ff;
   assign rsp_vel_z    = rsp_vel_z_ff;
   assign rsp_tracking = rsp_tracking_ff;

   // Conditions watched by the checks below.
   assign stepping   = (state_ff == BK_RUN) && (step_ff != vsvc_pkg::STEP_OUT);
   assign loading    = (state_ff == BK_RUN) && (step_ff == vsvc_pkg::STEP_OUT) && out_free;
   assign search_out = rsp_valid_ff && !rsp_tracking_ff;

   `VSVC_ASSERT_NEXT(a_step_advances, clock, reset, stepping, step_ff == $past(step_ff) + 3'd1)
   `VSVC_ASSERT_NEXT(a_result_loads, clock, reset, loading, rsp_valid_ff && state_ff == BK_IDLE)
   `VSVC_ASSERT_NOW(a_search_vz_zero, clock, reset, search_out, rsp_vel_z_ff == 24'd0)

endmodule

[sv/visual_servo_velocity_controller.sv]
// Proportional visual-servo velocity controller. A target item (operation 0)
// latches pixel position and depth and returns nothing; a control tick
// (operation 1) returns one x/y/z velocity, tracking the held target while
// its age is within timeout_ticks and otherwise tracing a search circle. The
// front end classifies each tick in the cycle of its transfer and queues it
// in a two-entry job queue; the back end picks up each job, runs five steps
// through its single shared 29x24 multiplier and loads the output register
// once rsp_stall allows; it picks up no new tick until the last is loaded,
// while target items and up to two queued ticks are taken at one per cycle
// while the job queue has room. Configuration registers are written through
// the csr_ port and should change only while no tick is in flight.
module visual_servo_velocity_controller (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_write,
   input  logic [2:0]         csr_index,
   input  logic [23:0]        csr_wdata,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_operation,
   input  logic [11:0]        req_pixel_u,
   input  logic [11:0]        req_pixel_v,
   input  logic [15:0]        req_depth,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [23:0] rsp_vel_x,
   output logic signed [23:0] rsp_vel_y,
   output logic signed [23:0] rsp_vel_z,
   output logic               rsp_tracking
);

   vsvc_pkg::cfg_type          cfg_ff, cfg_in;
   vsvc_pkg::push_type         push;
   vsvc_pkg::job_type          head;
   vsvc_pkg::queue_status_type status;
   logic                       pop;

   // Configuration register writes.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_index)
            vsvc_pkg::CSR_FRAME_WIDTH:   cfg_in.frame_width   = csr_wdata[12:0];
            vsvc_pkg::CSR_FRAME_HEIGHT:  cfg_in.frame_height  = csr_wdata[12:0];
            vsvc_pkg::CSR_GAIN_X:        cfg_in.gain_x        = csr_wdata;
            vsvc_pkg::CSR_GAIN_Y:        cfg_in.gain_y        = csr_wdata;
            vsvc_pkg::CSR_DEPTH_GAIN:    cfg_in.depth_gain    = csr_wdata[15:0];
            vsvc_pkg::CSR_DEFAULT_DEPTH: cfg_in.default_depth = csr_wdata[15:0];
            vsvc_pkg::CSR_DESIRED_DEPTH: cfg_in.desired_depth = csr_wdata[15:0];
            vsvc_pkg::CSR_TIMEOUT_TICKS: cfg_in.timeout_ticks = csr_wdata[7:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.frame_width   <= vsvc_pkg::RST_FRAME_WIDTH;
         cfg_ff.frame_height  <= vsvc_pkg::RST_FRAME_HEIGHT;
         cfg_ff.gain_x        <= vsvc_pkg::RST_GAIN_X;
         cfg_ff.gain_y        <= vsvc_pkg::RST_GAIN_Y;
         cfg_ff.depth_gain    <= vsvc_pkg::RST_DEPTH_GAIN;
         cfg_ff.default_depth <= vsvc_pkg::RST_DEFAULT_DEPTH;
         cfg_ff.desired_depth <= vsvc_pkg::RST_DESIRED_DEPTH;
         cfg_ff.timeout_ticks <= vsvc_pkg::RST_TIMEOUT_TICKS;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   vsvc_front u_front (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg_ff),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_operation (req_operation),
      .req_pixel_u   (req_pixel_u),
      .req_pixel_v   (req_pixel_v),
      .req_depth     (req_depth),
      .status        (status),
      .push          (push)
   );

   vsvc_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (push),
      .pop    (pop),
      .head   (head),
      .status (status)
   );

   vsvc_back u_back (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg_ff),
      .head         (head),
      .status       (status),
      .pop          (pop),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_vel_x    (rsp_vel_x),
      .rsp_vel_y    (rsp_vel_y),
      .rsp_vel_z    (rsp_vel_z),
      .rsp_tracking (rsp_tracking)
   );

endmodule
